[sv/ufe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the union-find engine.
// No dependencies; imported by ufe_core and union_find_engine.
package ufe_pkg;

  localparam int ROOT_W          = 10;
  localparam int COUNT_W         = 11;
  localparam int OP_W            = 2;
  localparam int FLAG_W          = 2;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 24;
  localparam int OUT_PAD_W       = OUT_DATA_W - ROOT_W - COUNT_W;
  localparam int MAX_ADDRESSABLE = 1 << ROOT_W;
  localparam int COUNT_LIMIT     = (1 << COUNT_W) - 1;

  localparam logic [COUNT_W-1:0] SETS_RESET   = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] ACTIVE_RESET = COUNT_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_FIND  = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SWEEP,
    C_WALK,
    C_COMP,
    C_DONE
  } core_state_t;

  typedef struct packed {
    op_t               op;
    logic [ROOT_W-1:0] first;
    logic [ROOT_W-1:0] second;
  } ufe_cmd_t;

  typedef struct packed {
    logic              ready;
    logic              done;
    logic [ROOT_W-1:0] root;
    logic              joined;
  } ufe_rsp_t;

endpackage

[sv/ufe_core.sv]
`timescale 1ns / 1ps
// Parent table and the sequencer that walks, compresses, links and sweeps it.
// Depends on ufe_pkg for the command, response and state types.
module ufe_core
  import ufe_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  ufe_cmd_t cmd,
  output ufe_rsp_t rsp
);

  localparam int DEPTH = (MAX_ELEMENTS < MAX_ADDRESSABLE) ? MAX_ELEMENTS : MAX_ADDRESSABLE;
  localparam int AW    = $clog2(DEPTH);

  core_state_t state_r, state_nxt;

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr, wr_data;

  logic [AW-1:0] node_r, node_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic [AW-1:0] second_r, second_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [AW-1:0] root_r, root_nxt;
  logic          phase_r, phase_nxt;
  logic          merge_r, merge_nxt;
  logic          joined_r, joined_nxt;

  // The single comparator shared by the walk and the compression pass.
  logic [AW-1:0] cmp_lhs, cmp_rhs;
  logic          hit;

  always_comb begin
    cmp_lhs = node_r;
    cmp_rhs = top_r;
    if (state_r == C_WALK) begin
      cmp_lhs = rd_data_r;
      cmp_rhs = node_r;
    end
  end

  assign hit = (cmp_lhs == cmp_rhs);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == OP_CLEAR) ? C_SWEEP : C_WALK;
        end
      end
      C_WALK: begin
        if (hit) begin
          state_nxt = C_COMP;
        end
      end
      C_COMP: begin
        if (hit) begin
          state_nxt = (merge_r && !phase_r) ? C_WALK : C_DONE;
        end
      end
      C_SWEEP: begin
        if (sweep_r == AW'(DEPTH - 1)) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = node_r;
    wr_en      = 1'b0;
    wr_addr    = node_r;
    wr_data    = top_r;
    node_nxt   = node_r;
    start_nxt  = start_r;
    top_nxt    = top_r;
    ra_nxt     = ra_r;
    second_nxt = second_r;
    sweep_nxt  = sweep_r;
    root_nxt   = root_r;
    phase_nxt  = phase_r;
    merge_nxt  = merge_r;
    joined_nxt = joined_r;
    unique case (state_r)
      C_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op) inside
            OP_FIND, OP_MERGE: begin
              node_nxt   = cmd.first[AW-1:0];
              start_nxt  = cmd.first[AW-1:0];
              second_nxt = cmd.second[AW-1:0];
              phase_nxt  = 1'b0;
              merge_nxt  = (cmd.op == OP_MERGE);
              joined_nxt = 1'b0;
              rd_en      = 1'b1;
              rd_addr    = cmd.first[AW-1:0];
            end
            default: begin
              sweep_nxt  = '0;
              root_nxt   = '0;
              joined_nxt = 1'b0;
            end
          endcase
        end
      end
      C_WALK: begin
        rd_en = 1'b1;
        if (hit) begin
          // Root reached: restart from the first node to compress the path.
          top_nxt  = node_r;
          node_nxt = start_r;
          rd_addr  = start_r;
        end else begin
          node_nxt = rd_data_r;
          rd_addr  = rd_data_r;
        end
      end
      C_COMP: begin
        if (!hit) begin
          // Point this node at the root while fetching the next one.
          wr_en    = 1'b1;
          wr_addr  = node_r;
          wr_data  = top_r;
          node_nxt = rd_data_r;
          rd_en    = 1'b1;
          rd_addr  = rd_data_r;
        end else if (merge_r && !phase_r) begin
          ra_nxt    = top_r;
          phase_nxt = 1'b1;
          node_nxt  = second_r;
          start_nxt = second_r;
          rd_en     = 1'b1;
          rd_addr   = second_r;
        end else if (merge_r) begin
          wr_en      = 1'b1;
          wr_addr    = ra_r;
          wr_data    = top_r;
          root_nxt   = top_r;
          joined_nxt = (ra_r != top_r);
        end else begin
          root_nxt = top_r;
        end
      end
      C_SWEEP: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
      end
      C_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_SWEEP;
      sweep_r  <= '0;
      joined_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sweep_r  <= sweep_nxt;
      joined_r <= joined_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    start_r  <= start_nxt;
    top_r    <= top_nxt;
    ra_r     <= ra_nxt;
    second_r <= second_nxt;
    root_r   <= root_nxt;
    phase_r  <= phase_nxt;
    merge_r  <= merge_nxt;
  end

  always_comb begin
    rsp.ready  = (state_r == C_IDLE);
    rsp.done   = (state_r == C_DONE);
    rsp.root   = ROOT_W'(root_r);
    rsp.joined = joined_r;
  end

endmodule

[sv/union_find_engine.sv]
`timescale 1ns / 1ps
// Top level of the union-find engine: stream ports, range checks, set count.
// Depends on ufe_pkg and instantiates ufe_core.
//
// Each operation is handled one at a time. A find walks from its element up
// to the root and then compresses the path: the parent table has one read
// and one write port, so the walk to the root and the compression pass each
// handle one node at a time. A merge runs both passes for its first and then
// its second element back to back and then writes the link. A clear rewrites
// the whole table, one entry a cycle; the same clearing pass runs after reset,
// and no input is taken until it has finished. Operations with an index error
// or the unused code have their result ready in the cycle after the transfer
// in. A write to the active element count takes effect at the next clear.
module union_find_engine
  import ufe_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_data,      // active_elements
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // first_index[9:0], second_index[19:10]
  input  logic [OP_W-1:0]       in_tuser,      // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,     // root[9:0], set_count[20:10]
  output logic [FLAG_W-1:0]     out_tuser      // joined[0], index_error[1]
);

  localparam int MAX_CLAMP = (MAX_ELEMENTS < COUNT_LIMIT) ? MAX_ELEMENTS : COUNT_LIMIT;
  localparam logic [COUNT_W-1:0] IN_USE_RESET =
    COUNT_W'((MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024);

  logic [COUNT_W-1:0] active_r;
  logic [COUNT_W-1:0] in_use_r, in_use_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]  out_root_r, out_root_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_joined_r, out_joined_nxt;
  logic               out_err_r, out_err_nxt;

  op_t                op;
  logic [ROOT_W-1:0]  first_idx, second_idx;
  logic               a_bad, b_bad, err_w, in_fire, launch;
  logic [COUNT_W-1:0] clamp_w, dec_w;

  ufe_cmd_t cmd;
  ufe_rsp_t rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_data;
    end
  end

  assign op         = op_t'(in_tuser);
  assign first_idx  = in_tdata[ROOT_W-1:0];
  assign second_idx = in_tdata[2*ROOT_W-1:ROOT_W];
  assign a_bad      = ({1'b0, first_idx} >= in_use_r);
  assign b_bad      = ({1'b0, second_idx} >= in_use_r);

  always_comb begin
    case (op)
      OP_FIND:  err_w = a_bad;
      OP_MERGE: err_w = a_bad || b_bad;
      default:  err_w = 1'b0;
    endcase
  end

  assign in_tready = rsp.ready && !pend_r && !out_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign launch    = in_fire && !err_w && (op != OP_NOP);

  // Register value as it stands at a clear, held within one and MAX_ELEMENTS (at most the count limit).
  always_comb begin
    if (active_r == '0) begin
      clamp_w = COUNT_W'(1);
    end else if (int'(active_r) > MAX_CLAMP) begin
      clamp_w = COUNT_W'(MAX_CLAMP);
    end else begin
      clamp_w = active_r;
    end
  end

  assign dec_w = (rsp.joined && count_r != '0) ? count_r - 1'b1 : count_r;

  always_comb begin
    cmd.op     = op;
    cmd.first  = first_idx;
    cmd.second = second_idx;
  end

  always_comb begin
    in_use_nxt     = in_use_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_root_nxt   = out_root_r;
    out_count_nxt  = out_count_r;
    out_joined_nxt = out_joined_r;
    out_err_nxt    = out_err_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (launch) begin
        pend_nxt = 1'b1;
        if (op == OP_CLEAR) begin
          in_use_nxt = clamp_w;
          count_nxt  = clamp_w;
        end
      end else begin
        out_valid_nxt  = 1'b1;
        out_root_nxt   = '0;
        out_count_nxt  = count_r;
        out_joined_nxt = 1'b0;
        out_err_nxt    = err_w;
      end
    end
    if (pend_r && rsp.done) begin
      pend_nxt       = 1'b0;
      count_nxt      = dec_w;
      out_valid_nxt  = 1'b1;
      out_root_nxt   = rsp.root;
      out_count_nxt  = dec_w;
      out_joined_nxt = rsp.joined;
      out_err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= IN_USE_RESET;
      count_r     <= SETS_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_use_r    <= in_use_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_root_r   <= out_root_nxt;
    out_count_r  <= out_count_nxt;
    out_joined_r <= out_joined_nxt;
    out_err_r    <= out_err_nxt;
  end

  ufe_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(launch),
    .cmd      (cmd),
    .rsp      (rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_count_r, out_root_r};
  assign out_tuser  = {out_err_r, out_joined_r};

  // A finished operation in the core always reaches the result register.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && rsp.done) |=> out_tvalid)
    else $error("core completion did not produce a result");

  // No new operation is taken while one is still in the core.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_tready)
    else $error("input accepted while an operation is outstanding");

  // A join can only be reported for an operation that this side launched.
  a_join_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.done && rsp.joined) |-> pend_r)
    else $error("core reported a join with no operation outstanding");

  // A set count only moves down by one on a join, or is reloaded by a clear.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && rsp.done && !rsp.joined) |=> $stable(count_r))
    else $error("set count changed without a join");

endmodule
